FILE: rtl/core/cwc_pkg.sv
// Package with shared types and constants for the coin window classifier.
package cwc_pkg;

	localparam int NUM_TYPES_DEF   = 16;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int READ_W  = 12;
	localparam int BOUND_W = 13;
	localparam int VAL_W   = 14;
	localparam int MONEY_W = 16;
	localparam int CNT_W   = 32;
	localparam int NCH     = 3;

	typedef logic signed [VAL_W-1:0] cwc_val_t;

	typedef struct packed {
		logic [NCH-1:0][BOUND_W-1:0] lo;
		logic [NCH-1:0][BOUND_W-1:0] hi;
		logic [MONEY_W-1:0]          money;
	} cwc_entry_t;

endpackage

FILE: rtl/core/cwc_table.sv
// Coin type table memory: one write port, one registered read port.
module cwc_table
	import cwc_pkg::*;
#(
	parameter int NUM_TYPES = NUM_TYPES_DEF,
	parameter int IW        = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  cwc_entry_t    wr_data,
	input  logic [IW-1:0] rd_addr,
	output cwc_entry_t    rd_data
);

	cwc_entry_t mem [NUM_TYPES];
	cwc_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/cwc_window.sv
// Shared window compare unit: checks three channel values against one entry.
module cwc_window
	import cwc_pkg::*;
(
	input  cwc_val_t             vals [NCH],
	input  cwc_entry_t           entry,
	output logic                 hit
);

	logic [NCH-1:0] ok;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			ok[c] = (vals[c] >= $signed({entry.lo[c][BOUND_W-1], entry.lo[c]})) &&
			        (vals[c] <= $signed({entry.hi[c][BOUND_W-1], entry.hi[c]}));
		end
	end

	assign hit = &ok;

endmodule

FILE: rtl/core/coin_window_classifier_tally.sv
// Top level of the coin classifier: sequencer, tally memory and counters.
// Load request: the table entry is written at the edge that accepts it.
// Classify request: scans one table entry per cycle; on a match the tally is read (TRD)
// and written back (TWR), then the result is registered in DONE once the output is free;
// a reject goes straight to DONE. Input stalls until the sequencer is back in IDLE.
// Reset clears valid bits and counters at once; no clearing pass.
module coin_window_classifier_tally
	import cwc_pkg::*;
#(
	parameter int NUM_TYPES   = NUM_TYPES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic [3:0]                type_index,
	input  logic signed [BOUND_W-1:0] window_low0,
	input  logic signed [BOUND_W-1:0] window_high0,
	input  logic signed [BOUND_W-1:0] window_low1,
	input  logic signed [BOUND_W-1:0] window_high1,
	input  logic signed [BOUND_W-1:0] window_low2,
	input  logic signed [BOUND_W-1:0] window_high2,
	input  logic [MONEY_W-1:0]        face_value,
	input  logic [READ_W-1:0]         reading0,
	input  logic [READ_W-1:0]         reading1,
	input  logic [READ_W-1:0]         reading2,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      genuine,
	output logic [3:0]                coin_type,
	output logic [CNT_W-1:0]          type_tally,
	output logic [CNT_W-1:0]          good_total,
	output logic [CNT_W-1:0]          reject_total,
	output logic [CNT_W-1:0]          money_total,
	output logic [CNT_W-1:0]          coin_total
);

	localparam int IW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam logic [READ_W-1:0] SAMPLE_MASK =
		(SAMPLE_BITS >= READ_W) ? {READ_W{1'b1}} : READ_W'((1 << SAMPLE_BITS) - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_TRD  = 3'd2;
	localparam logic [2:0] ST_TWR  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]           state_q;
	logic                 diff_mode_q;
	logic [NUM_TYPES-1:0] entry_vld_q;
	logic [NUM_TYPES-1:0] tally_vld_q;
	logic [IW:0]          ptr_q;
	logic                 rd_vld_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [IW-1:0]        found_q;
	logic                 match_q;
	logic [MONEY_W-1:0]   money_q;
	logic [CNT_W-1:0]     tally_q;
	logic [CNT_W-1:0]     tally_rd_q;
	logic [CNT_W-1:0]     tally_new;
	logic [CNT_W-1:0]     tally_mem [NUM_TYPES];
	cwc_val_t             vals_q [NCH];

	logic [CNT_W-1:0] good_q, reject_q, money_sum_q, coin_q;

	logic                 in_acc;
	logic                 load_en;
	logic                 out_free;
	logic [READ_W-1:0]    r0, r1, r2;
	cwc_entry_t           wr_entry;
	cwc_entry_t           rd_entry;
	logic                 win_hit;
	logic                 hit;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign load_en   = in_acc && !op && ($unsigned(type_index) < NUM_TYPES);
	assign out_free  = !out_valid || !out_stall;

	assign r0 = reading0 & SAMPLE_MASK;
	assign r1 = reading1 & SAMPLE_MASK;
	assign r2 = reading2 & SAMPLE_MASK;

	assign wr_entry.lo    = {window_low2, window_low1, window_low0};
	assign wr_entry.hi    = {window_high2, window_high1, window_high0};
	assign wr_entry.money = face_value;

	cwc_table #(
		.NUM_TYPES(NUM_TYPES),
		.IW       (IW)
	) u_table (
		.clk    (clk),
		.wr_en  (load_en),
		.wr_addr(IW'(type_index)),
		.wr_data(wr_entry),
		.rd_addr(ptr_q[IW-1:0]),
		.rd_data(rd_entry)
	);

	cwc_window u_window (
		.vals (vals_q),
		.entry(rd_entry),
		.hit  (win_hit)
	);

	assign hit = rd_vld_s1 && entry_vld_q[rd_idx_s1] && win_hit;

	assign tally_new = (tally_vld_q[found_q] ? tally_rd_q : '0) + CNT_W'(1);

	always_ff @(posedge clk) begin
		tally_rd_q <= tally_mem[found_q];
		if (state_q == ST_TWR) begin
			tally_mem[found_q] <= tally_new;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && op) begin
			vals_q[0] <= cwc_val_t'({2'b00, r0});
			if (diff_mode_q) begin
				vals_q[1] <= cwc_val_t'({2'b00, r1}) - cwc_val_t'({2'b00, r0});
				vals_q[2] <= cwc_val_t'({2'b00, r2}) - cwc_val_t'({2'b00, r1});
			end else begin
				vals_q[1] <= cwc_val_t'({2'b00, r1});
				vals_q[2] <= cwc_val_t'({2'b00, r2});
			end
		end
		rd_idx_s1 <= ptr_q[IW-1:0];
		if (state_q == ST_SCAN && hit) begin
			found_q <= rd_idx_s1;
			money_q <= rd_entry.money;
		end
		if (state_q == ST_TWR) begin
			tally_q <= tally_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			diff_mode_q  <= 1'b1;
			entry_vld_q  <= '0;
			tally_vld_q  <= '0;
			ptr_q        <= '0;
			rd_vld_s1    <= 1'b0;
			match_q      <= 1'b0;
			good_q       <= '0;
			reject_q     <= '0;
			money_sum_q  <= '0;
			coin_q       <= '0;
			out_valid    <= 1'b0;
			genuine      <= 1'b0;
			coin_type    <= '0;
			type_tally   <= '0;
			good_total   <= '0;
			reject_total <= '0;
			money_total  <= '0;
			coin_total   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				diff_mode_q <= cfg_data;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (load_en) begin
				entry_vld_q[IW'(type_index)] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					ptr_q     <= '0;
					rd_vld_s1 <= 1'b0;
					if (in_acc && op) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= (ptr_q < (IW+1)'(NUM_TYPES));
					if (ptr_q < (IW+1)'(NUM_TYPES)) begin
						ptr_q <= ptr_q + (IW+1)'(1);
					end
					if (hit) begin
						match_q   <= 1'b1;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_TRD;
					end else if (rd_vld_s1 && rd_idx_s1 == IW'(NUM_TYPES - 1)) begin
						match_q   <= 1'b0;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_DONE;
					end
				end
				ST_TRD: begin
					state_q <= ST_TWR;
				end
				ST_TWR: begin
					tally_vld_q[found_q] <= 1'b1;
					state_q              <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						coin_q     <= coin_q + CNT_W'(1);
						coin_total <= coin_q + CNT_W'(1);
						if (match_q) begin
							good_q       <= good_q + CNT_W'(1);
							money_sum_q  <= money_sum_q + CNT_W'(money_q);
							genuine      <= 1'b1;
							coin_type    <= 4'(found_q);
							type_tally   <= tally_q;
							good_total   <= good_q + CNT_W'(1);
							money_total  <= money_sum_q + CNT_W'(money_q);
							reject_total <= reject_q;
						end else begin
							reject_q     <= reject_q + CNT_W'(1);
							genuine      <= 1'b0;
							coin_type    <= '0;
							type_tally   <= '0;
							good_total   <= good_q;
							money_total  <= money_sum_q;
							reject_total <= reject_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
